// ===== src/lst_pkg.sv =====
// lst_pkg: shared types, constants and helpers of the logical interface slot table
// depends on nothing; used by every module of the block except lst_ram
package lst_pkg;

   // fixed field widths of the channels
   localparam int LIN_W = 10;
   localparam int GRP_W = 5;
   localparam int OP_W = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // bitmap word layout
   localparam int WORD_W = 32;
   localparam int WORD_LOG = 5;

   // defaults for the top-level parameters
   localparam int DEF_SLOT_COUNT = 1024;
   localparam int DEF_FIRST_SLOT = 1;

   // reset value of the invalid group code register
   localparam logic [GRP_W-1:0] INVALID_RESET = 5'd31;

   // depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_SET     = 2'd2,
      OP_GET     = 2'd3
   } op_type;

   // classified command as it travels through the queue
   typedef struct packed {
      op_type           op;
      logic [LIN_W-1:0] lin_id;
      logic [GRP_W-1:0] group_id;
      logic             in_range;
   } cmd_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   // result beat layout: status, slot_out, group_out from bit 0 up
   function automatic logic [RSP_DATA_W-1:0] pack_rsp(input logic status,
                                                       input logic [LIN_W-1:0] slot,
                                                       input logic [GRP_W-1:0] group);
      pack_rsp = {group, slot, status};
   endfunction

endpackage

// ===== src/lst_ram.sv =====
// lst_ram: generic single-write, single-read memory with registered read data
// depends on nothing
module lst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lst_front.sv =====
// lst_front: accepts request beats, decodes the operation and checks the slot range
// depends on lst_pkg
module lst_front #(
   parameter int SLOT_COUNT = lst_pkg::DEF_SLOT_COUNT
) (
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lst_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic [lst_pkg::OP_W-1:0]             req_tuser,
   input  logic                                 queue_full,
   output logic                                 push,
   output lst_pkg::cmd_type                     cmd
);

   // compare width holds both the slot count and the id field
   localparam int CW = ($clog2(SLOT_COUNT) + 1 > lst_pkg::LIN_W) ?
                       $clog2(SLOT_COUNT) + 1 : lst_pkg::LIN_W;

   logic [lst_pkg::LIN_W-1:0] lin_id;
   logic [lst_pkg::GRP_W-1:0] group_id;

   assign lin_id   = req_tdata[lst_pkg::LIN_W-1:0];
   assign group_id = req_tdata[lst_pkg::LIN_W +: lst_pkg::GRP_W];

   // take a beat whenever the queue has room
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // classify the beat
   always_comb begin
      cmd.op       = lst_pkg::op_type'(req_tuser);
      cmd.lin_id   = lin_id;
      cmd.group_id = group_id;
      cmd.in_range = CW'(lin_id) < CW'(SLOT_COUNT);
   end

endmodule

// ===== src/lst_cmd_queue.sv =====
// lst_cmd_queue: short command queue that decouples the front end from the back end
// depends on lst_pkg
module lst_cmd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lst_pkg::cmd_type        push_cmd,
   output logic                    full,
   input  logic                    pop,
   output lst_pkg::queue_head_type head
);

   localparam int DEPTH = lst_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   lst_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full       = (count_ff == (PTR_W+1)'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/lst_back.sv =====
// lst_back: executes queued commands against the used-slot bitmap and group table
// depends on lst_pkg and lst_ram
module lst_back #(
   parameter int SLOT_COUNT = lst_pkg::DEF_SLOT_COUNT,
   parameter int FIRST_SLOT = lst_pkg::DEF_FIRST_SLOT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lst_pkg::queue_head_type        head,
   output logic                           pop,
   input  logic [lst_pkg::GRP_W-1:0]      invalid_code,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lst_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W   = $clog2(SLOT_COUNT);
   localparam int WORDS   = (SLOT_COUNT + lst_pkg::WORD_W - 1) / lst_pkg::WORD_W;
   localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int GW      = WADDR_W + lst_pkg::WORD_LOG;
   localparam int GT_W    = lst_pkg::GRP_W + 1;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_ALLOC  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   logic [IDX_W-1:0]                clr_ff, clr_in;
   lst_pkg::cmd_type                cur_ff, cur_in;
   logic [WADDR_W:0]                rd_w_ff, rd_w_in;
   logic [WADDR_W-1:0]              chk_w_ff, chk_w_in;
   logic                            dv_ff, dv_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lst_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // memory ports
   logic                            bm_we;
   logic [WADDR_W-1:0]              bm_waddr, bm_raddr;
   logic [lst_pkg::WORD_W-1:0]      bm_wdata, bm_rdata;
   logic                            gt_we;
   logic [IDX_W-1:0]                gt_waddr, gt_raddr;
   logic [GT_W-1:0]                 gt_wdata, gt_rdata;

   // index helpers
   logic [IDX_W-1:0]                idx_q, idx_c;
   logic [lst_pkg::WORD_LOG-1:0]    bit_c;
   logic                            out_free;

   // word scan
   logic [lst_pkg::WORD_W-1:0]      free_vec;
   logic [lst_pkg::WORD_LOG-1:0]    free_bit;
   logic                            free_any;
   logic [GW-1:0]                   grant;
   logic [lst_pkg::GRP_W-1:0]       get_group;

   lst_ram #(.WIDTH(lst_pkg::WORD_W), .DEPTH(WORDS)) u_bitmap (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (bm_wdata),
      .rd_addr (bm_raddr),
      .rd_data (bm_rdata)
   );

   lst_ram #(.WIDTH(GT_W), .DEPTH(SLOT_COUNT)) u_group (
      .clock   (clock),
      .wr_en   (gt_we),
      .wr_addr (gt_waddr),
      .wr_data (gt_wdata),
      .rd_addr (gt_raddr),
      .rd_data (gt_rdata)
   );

   assign idx_q    = IDX_W'(head.cmd.lin_id);
   assign idx_c    = IDX_W'(cur_ff.lin_id);
   assign bit_c    = lst_pkg::WORD_LOG'(idx_c);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign pop      = (state_ff == ST_IDLE) && head.valid && out_free;

   // free bits of the word under check, slots outside the usable range count as used
   always_comb begin
      logic [GW-1:0] g;
      for (int b = 0; b < lst_pkg::WORD_W; b++) begin
         g = {chk_w_ff, lst_pkg::WORD_LOG'(b)};
         free_vec[b] = !bm_rdata[b] && (g >= GW'(FIRST_SLOT)) &&
                       ({1'b0, g} < (GW+1)'(SLOT_COUNT));
      end
   end

   // lowest free bit
   always_comb begin
      free_bit = '0;
      for (int b = lst_pkg::WORD_W - 1; b >= 0; b--) begin
         if (free_vec[b]) begin
            free_bit = lst_pkg::WORD_LOG'(b);
         end
      end
   end

   assign free_any  = |free_vec;
   assign grant     = {chk_w_ff, free_bit};
   assign get_group = (cur_ff.in_range && gt_rdata[lst_pkg::GRP_W]) ?
                      gt_rdata[lst_pkg::GRP_W-1:0] : invalid_code;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      rd_w_in      = rd_w_ff;
      chk_w_in     = chk_w_ff;
      dv_in        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      bm_we        = 1'b0;
      bm_waddr     = WADDR_W'(idx_c >> lst_pkg::WORD_LOG);
      bm_wdata     = '0;
      bm_raddr     = WADDR_W'(rd_w_ff);
      gt_we        = 1'b0;
      gt_waddr     = idx_c;
      gt_wdata     = '0;
      gt_raddr     = idx_q;
      case (state_ff)
         ST_CLEAR: begin
            // sweep both tables back to zero after reset
            gt_we    = 1'b1;
            gt_waddr = clr_ff;
            bm_we    = ({1'b0, clr_ff} < (IDX_W+1)'(WORDS));
            bm_waddr = WADDR_W'(clr_ff);
            if (clr_ff == IDX_W'(SLOT_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (pop) begin
               cur_in = head.cmd;
               case (head.cmd.op)
                  lst_pkg::OP_ALLOC: begin
                     bm_raddr = '0;
                     rd_w_in  = (WADDR_W+1)'(1);
                     chk_w_in = '0;
                     dv_in    = 1'b1;
                     state_in = ST_ALLOC;
                  end
                  lst_pkg::OP_SET: begin
                     gt_we        = head.cmd.in_range;
                     gt_waddr     = idx_q;
                     gt_wdata     = {1'b1, head.cmd.group_id};
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = lst_pkg::pack_rsp(1'b0, '0, '0);
                  end
                  lst_pkg::OP_RELEASE: begin
                     bm_raddr = WADDR_W'(idx_q >> lst_pkg::WORD_LOG);
                     state_in = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_ALLOC: begin
            // one word read issued per cycle, checked in the next cycle
            if (rd_w_ff < (WADDR_W+1)'(WORDS)) begin
               rd_w_in  = rd_w_ff + (WADDR_W+1)'(1);
               chk_w_in = WADDR_W'(rd_w_ff);
               dv_in    = 1'b1;
            end
            if (dv_ff) begin
               if (free_any) begin
                  bm_we        = 1'b1;
                  bm_waddr     = chk_w_ff;
                  bm_wdata     = bm_rdata | (lst_pkg::WORD_W'(1) << free_bit);
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = lst_pkg::pack_rsp(1'b0, lst_pkg::LIN_W'(grant), '0);
                  dv_in        = 1'b0;
                  state_in     = ST_IDLE;
               end else if (chk_w_ff == WADDR_W'(WORDS - 1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = lst_pkg::pack_rsp(1'b1, '0, '0);
                  dv_in        = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_FINISH: begin
            // release writes back, get returns the looked-up group
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (cur_ff.op == lst_pkg::OP_RELEASE) begin
               bm_we       = cur_ff.in_range;
               bm_wdata    = bm_rdata & ~(lst_pkg::WORD_W'(1) << bit_c);
               gt_we       = cur_ff.in_range;
               rsp_data_in = lst_pkg::pack_rsp(1'b0, '0, '0);
            end else begin
               rsp_data_in = lst_pkg::pack_rsp(1'b0, '0, get_group);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rd_w_ff     <= rd_w_in;
      chk_w_ff    <= chk_w_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== src/logical_interface_slot_table_core.sv =====
// Logical interface slot table, top level: front end, command queue, back end, csr.
// Set answers from the idle state, release and get through the finish state; allocate reads
// one 32-bit bitmap word per cycle from word 0 until a free slot or the last word is found.
// Throughput: one item at a time in the back end, which takes the next command only when
// it is back in idle and the result register is free.
// Reset: synchronous; a clearing pass over all SLOT_COUNT table addresses zeroes the tables,
// during which up to two request beats are queued and csr writes are taken.
// depends on lst_pkg, lst_front, lst_cmd_queue, lst_back
module logical_interface_slot_table_core #(
   parameter int SLOT_COUNT = lst_pkg::DEF_SLOT_COUNT,
   parameter int FIRST_SLOT = lst_pkg::DEF_FIRST_SLOT
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [lst_pkg::REQ_DATA_W-1:0] req_tdata,  // lin_id[9:0], group_id[14:10]
   input  logic [lst_pkg::OP_W-1:0]       req_tuser,  // operation[1:0]
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lst_pkg::RSP_DATA_W-1:0] rsp_tdata,  // status[0], slot_out[10:1], group_out[15:11]
   // configuration
   input  logic                           csr_wr_en,
   input  logic [lst_pkg::GRP_W-1:0]      csr_wr_data
);

   logic                      push;
   logic                      queue_full;
   logic                      pop;
   lst_pkg::cmd_type          push_cmd;
   lst_pkg::queue_head_type   head;
   logic [lst_pkg::GRP_W-1:0] inv_code_ff, inv_code_in;

   // invalid group code register
   assign inv_code_in = csr_wr_en ? csr_wr_data : inv_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_code_ff <= lst_pkg::INVALID_RESET;
      end else begin
         inv_code_ff <= inv_code_in;
      end
   end

   lst_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   lst_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head     (head)
   );

   lst_back #(.SLOT_COUNT(SLOT_COUNT), .FIRST_SLOT(FIRST_SLOT)) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .invalid_code (inv_code_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

// ===== src/lst_checker.sv =====
// lst_port_checks: port-level assertions on the slot table, bound to the top level
// depends on logical_interface_slot_table_core
module lst_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // no result beat right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat during reset");

   // a full report carries no slot and no group
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[10:1] == 10'd0 && rsp_tdata[15:11] == 5'd0)
      else $error("full report with payload");

   // a granted slot comes with success and no group
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10:1] != 10'd0 |-> !rsp_tdata[0] && rsp_tdata[15:11] == 5'd0)
      else $error("grant mixed with other result");

endmodule

bind logical_interface_slot_table_core lst_port_checks u_lst_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/sv/lst_checker.sv =====
`timescale 1ns / 100ps
// lst_checker: watches the request, result and csr channels of the slot table core,
// keeps its own copy of the three slot tables and compares every result beat
// depends on lst_pkg
module lst_checker
   import lst_pkg::*;
#(
   parameter int SLOT_COUNT = DEF_SLOT_COUNT,
   parameter int FIRST_SLOT = DEF_FIRST_SLOT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // lin_id[9:0], group_id[14:10]
   input  logic [OP_W-1:0]       req_tuser,  // operation[1:0]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // status[0], slot_out[10:1], group_out[15:11]
   input  logic                  csr_wr_en,
   input  logic [GRP_W-1:0]      csr_wr_data,
   output int                    fail_count,
   output int                    pending_count
);

   // result beat, status in bit 0
   typedef struct packed {
      logic [GRP_W-1:0] group;
      logic [LIN_W-1:0] slot;
      logic             status;
   } slot_result_type;

   // shadow tables and register
   logic             slot_used  [SLOT_COUNT];
   logic [GRP_W-1:0] slot_group [SLOT_COUNT];
   logic             slot_tx_en [SLOT_COUNT];
   logic [GRP_W-1:0] invalid_code;

   slot_result_type expected_results[$];

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("lst_checker: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // apply one command to the shadow tables and return its result beat
   function automatic slot_result_type predict_table_op(input op_type op,
                                                        input logic [LIN_W-1:0] lin,
                                                        input logic [GRP_W-1:0] grp);
      slot_result_type res;
      logic found;
      logic in_range;
      res = '0;
      found = 1'b0;
      in_range = (int'(lin) < SLOT_COUNT);
      case (op)
         OP_ALLOC: begin
            // lowest free slot from the first usable one
            for (int i = FIRST_SLOT; i < SLOT_COUNT; i++) begin
               if (!found && !slot_used[i]) begin
                  slot_used[i] = 1'b1;
                  res.slot = LIN_W'(i);
                  found = 1'b1;
               end
            end
            res.status = !found;
         end
         OP_RELEASE: begin
            if (in_range) begin
               slot_used[lin] = 1'b0;
               slot_group[lin] = '0;
               slot_tx_en[lin] = 1'b0;
            end
         end
         OP_SET: begin
            if (in_range) begin
               slot_group[lin] = grp;
               slot_tx_en[lin] = 1'b1;
            end
         end
         default: begin
            if (in_range && slot_tx_en[lin])
               res.group = slot_group[lin];
            else
               res.group = invalid_code;
         end
      endcase
      return res;
   endfunction

   // sample all channels at the rising edge
   always @(posedge clock) begin : watch
      slot_result_type got;
      slot_result_type want;
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_used[i] = 1'b0;
            slot_group[i] = '0;
            slot_tx_en[i] = 1'b0;
         end
         invalid_code = INVALID_RESET;
         expected_results.delete();
      end else begin
         if (csr_wr_en)
            invalid_code = csr_wr_data;
         // result beat against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_results.size() == 0) begin
               flag_mismatch("result beat with nothing expected, tdata", int'(got), 0);
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status)
                  flag_mismatch("status", int'(got.status), int'(want.status));
               if (got.slot !== want.slot)
                  flag_mismatch("slot_out", int'(got.slot), int'(want.slot));
               if (got.group !== want.group)
                  flag_mismatch("group_out", int'(got.group), int'(want.group));
            end
         end
         // request beat updates the shadow tables
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_table_op(op_type'(req_tuser),
                                                        req_tdata[LIN_W-1:0],
                                                        req_tdata[LIN_W+GRP_W-1:LIN_W]));
      end
      pending_count = expected_results.size();
   end

endmodule

// ===== tb/sv/tb_logical_interface_slot_table_core.sv =====
`timescale 1ns / 100ps
// tb_logical_interface_slot_table_core: clock, reset, request and result traffic and
// csr writes for the slot table core; the verdict comes from the checker's failure count
// depends on lst_pkg, lst_checker, logical_interface_slot_table_core
module tb_logical_interface_slot_table_core;
   import lst_pkg::*;

   localparam int CYCLE_LIMIT = 800000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;  // lin_id[9:0], group_id[14:10]
   logic [OP_W-1:0]       req_tuser;  // operation[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // status[0], slot_out[10:1], group_out[15:11]
   logic                  csr_wr_en;
   logic [GRP_W-1:0]      csr_wr_data;

   int fail_count;
   int pending_count;
   int cycle_count;

   // pacing controls of the request source and the result sink
   bit source_pace;
   bit sink_pace;
   bit hold_off_req;

   logical_interface_slot_table_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lst_checker CHECK (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("logical_interface_slot_table_core: mismatch");
      $finish;
   end

   // result sink: random stall per beat, one long hold-off on request
   initial begin : result_sink
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = sink_pace ? $urandom_range(0, 19) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         @(negedge clock);
      end
   end

   // one request beat; entered and left at a falling edge
   task automatic send_request(input op_type op, input logic [LIN_W-1:0] lin,
                               input logic [GRP_W-1:0] grp);
      int gap;
      gap = source_pace ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, grp, lin};
      req_tuser <= op;
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_invalid_code(input logic [GRP_W-1:0] code);
      csr_wr_en <= 1'b1;
      csr_wr_data <= code;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // slot id biased toward the low words and the ends
   function automatic logic [LIN_W-1:0] pick_slot();
      logic [LIN_W-1:0] lin;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: lin = '0;
               1: lin = 10'd1;
               2: lin = 10'd1022;
               default: lin = '1;
            endcase
         end
         1, 2, 3: lin = LIN_W'($urandom_range(0, 63));
         default: lin = LIN_W'($urandom_range(0, 1023));
      endcase
      return lin;
   endfunction

   // random mix of all four operations
   task automatic run_mixed_traffic(input int count);
      op_type op;
      int pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)
            op = OP_ALLOC;
         else if (pick < 50)
            op = OP_RELEASE;
         else if (pick < 75)
            op = OP_SET;
         else
            op = OP_GET;
         send_request(op, pick_slot(), GRP_W'($urandom_range(0, 31)));
      end
   endtask

   // allocate past the table size, with some set and get beats mixed in
   task automatic fill_slot_table(input int alloc_total);
      int allocs;
      allocs = 0;
      while (allocs < alloc_total) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request($urandom_range(0, 1) ? OP_SET : OP_GET, pick_slot(),
                         GRP_W'($urandom_range(0, 31)));
         end else begin
            send_request(OP_ALLOC, LIN_W'($urandom_range(0, 1023)),
                         GRP_W'($urandom_range(0, 31)));
            allocs++;
         end
      end
   endtask

   // stimulus and verdict
   initial begin : stimulus
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_ALLOC;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      source_pace = 1'b1;
      sink_pace = 1'b1;
      hold_off_req = 1'b0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: invalid code at reset value
      send_request(OP_GET, 10'd0, 5'd0);
      send_request(OP_GET, 10'd1023, 5'd31);
      send_request(OP_ALLOC, 10'd0, 5'd0);
      send_request(OP_ALLOC, 10'd1023, 5'd31);
      // slot below the first usable one, set while free
      send_request(OP_SET, 10'd0, 5'd31);
      send_request(OP_GET, 10'd0, 5'd0);
      send_request(OP_SET, 10'd1, 5'd0);
      send_request(OP_GET, 10'd1, 5'd31);
      send_request(OP_SET, 10'd1023, 5'd21);
      send_request(OP_GET, 10'd1023, 5'd0);
      // release of a free slot still clears group and enable
      send_request(OP_RELEASE, 10'd1023, 5'd31);
      send_request(OP_GET, 10'd1023, 5'd0);
      send_request(OP_RELEASE, 10'd1, 5'd0);
      send_request(OP_GET, 10'd1, 5'd0);
      send_request(OP_ALLOC, 10'd0, 5'd0);
      send_request(OP_RELEASE, 10'd0, 5'd0);
      send_request(OP_ALLOC, 10'd0, 5'd0);
      send_request(OP_SET, 10'd682, 5'd10);
      send_request(OP_GET, 10'd682, 5'd0);
      send_request(OP_SET, 10'd341, 5'd21);
      send_request(OP_GET, 10'd341, 5'd0);
      send_request(OP_RELEASE, 10'd2, 5'd0);
      send_request(OP_ALLOC, 10'd0, 5'd0);
      drain_block();

      // invalid code at zero, no idling on either side
      write_invalid_code(5'd0);
      source_pace = 1'b0;
      sink_pace = 1'b0;
      run_mixed_traffic(200);
      drain_block();

      // fill to table full, then refill single holes deep in the bitmap
      write_invalid_code(5'd31);
      source_pace = 1'b1;
      sink_pace = 1'b1;
      fill_slot_table(1030);
      repeat (20) begin
         send_request(OP_RELEASE, LIN_W'($urandom_range(1, 1023)),
                      GRP_W'($urandom_range(0, 31)));
         send_request(OP_ALLOC, LIN_W'($urandom_range(0, 1023)),
                      GRP_W'($urandom_range(0, 31)));
         send_request(OP_ALLOC, LIN_W'($urandom_range(0, 1023)),
                      GRP_W'($urandom_range(0, 31)));
      end
      drain_block();

      // long result hold-off while requests keep coming
      write_invalid_code(GRP_W'($urandom_range(0, 31)));
      source_pace = 1'b0;
      hold_off_req = 1'b1;
      run_mixed_traffic(40);
      drain_block();

      // random settings and pacing
      repeat (4) begin
         write_invalid_code(GRP_W'($urandom_range(0, 31)));
         source_pace = 1'($urandom_range(0, 1));
         sink_pace = 1'($urandom_range(0, 1));
         run_mixed_traffic(120);
         drain_block();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("logical_interface_slot_table_core: match");
      else
         $display("logical_interface_slot_table_core: mismatch");
      $finish;
   end

endmodule
